[design/kmns_pkg.sv]
// Shared constants, command codes and types of the keyboard matrix scanner.
`timescale 1ns / 1ps

package kmns_pkg;

    localparam int ROW_COUNT = 9;
    localparam int ROW_IDX_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

    localparam logic [4:0] ROW_COUNT_EXT = 5'(ROW_COUNT);

    localparam logic [1:0] CMD_BUS_WRITE  = 2'd0;
    localparam logic [1:0] CMD_BUS_READ   = 2'd1;
    localparam logic [1:0] CMD_KEY_UPDATE = 2'd2;

    localparam logic [7:0] BYTE_MASK = 8'hFF;

    typedef struct packed {
        logic       bus_write;
        logic       bus_read;
        logic       key_update;
        logic [7:0] write_value;
        logic [3:0] key_row;
        logic [7:0] key_bits;
        logic       key_down;
    } dp_cmd_t;

endpackage

[design/kmns_if.sv]
// Valid/ready channel interfaces for input items and read results.
`timescale 1ns / 1ps

interface kmns_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] write_value;
    logic [3:0] key_row;
    logic [7:0] key_bits;
    logic       key_down;

    modport source (output valid, cmd, write_value, key_row, key_bits, key_down,
                    input ready);
    modport sink (input valid, cmd, write_value, key_row, key_bits, key_down,
                  output ready);
endinterface

interface kmns_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink (input valid, read_data, output ready);
endinterface

[design/kmns_ctrl.sv]
// Handshake controller: accepts items, decodes commands, tracks the result register.
`timescale 1ns / 1ps

module kmns_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_cmd,
    input  logic [7:0]       write_value,
    input  logic [3:0]       key_row,
    input  logic [7:0]       key_bits,
    input  logic             key_down,
    output logic             out_valid,
    input  logic             out_ready,
    output kmns_pkg::dp_cmd_t dp_cmd
);

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready  = (state_reg == ST_EMPTY) || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == ST_FULL);

    always_comb
    begin
        dp_cmd             = '0;
        dp_cmd.write_value = write_value;
        dp_cmd.key_row     = key_row;
        dp_cmd.key_bits    = key_bits;
        dp_cmd.key_down    = key_down;
        if (accept)
        begin
            unique case (in_cmd)
                kmns_pkg::CMD_BUS_WRITE:  dp_cmd.bus_write  = 1'b1;
                kmns_pkg::CMD_BUS_READ:   dp_cmd.bus_read   = 1'b1;
                kmns_pkg::CMD_KEY_UPDATE: dp_cmd.key_update = 1'b1;
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (dp_cmd.bus_read)
            state_next = ST_FULL;
        else if (out_ready)
            state_next = ST_EMPTY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_EMPTY;
        else
            state_reg <= state_next;
    end

endmodule

[design/kmns_dp.sv]
// Datapath: row masks, row counter, column half, enable flag and read result register.
`timescale 1ns / 1ps

module kmns_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  kmns_pkg::dp_cmd_t dp_cmd,
    output logic [7:0]        read_data
);

    logic [7:0] key_rows_reg [kmns_pkg::ROW_COUNT];
    logic [3:0] row_counter_reg;
    logic [3:0] row_counter_next;
    logic       column_half_reg;
    logic       port_enabled_reg;
    logic [7:0] read_data_reg;
    logic [7:0] read_data_next;
    logic [7:0] sel_mask;
    logic [4:0] row_inc;
    logic       key_row_ok;

    assign key_row_ok = {1'b0, dp_cmd.key_row} < kmns_pkg::ROW_COUNT_EXT;
    assign row_inc    = {1'b0, row_counter_reg} + 5'd1;

    always_comb
    begin
        row_counter_next = row_counter_reg;
        if (dp_cmd.write_value[0])
            row_counter_next = '0;
        else if (!dp_cmd.write_value[1] && column_half_reg)
            row_counter_next = (row_inc >= kmns_pkg::ROW_COUNT_EXT) ? 4'd0 : row_inc[3:0];
    end

    always_comb
    begin
        if ({1'b0, row_counter_reg} < kmns_pkg::ROW_COUNT_EXT)
            sel_mask = key_rows_reg[row_counter_reg[kmns_pkg::ROW_IDX_W-1:0]];
        else
            sel_mask = '0;
        if (!port_enabled_reg)
            read_data_next = '0;
        else if (column_half_reg)
            read_data_next = ~{3'b000, sel_mask[3:0], 1'b0} & kmns_pkg::BYTE_MASK;
        else
            read_data_next = ~{3'b000, sel_mask[7:4], 1'b0} & kmns_pkg::BYTE_MASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_counter_reg  <= '0;
            column_half_reg  <= 1'b0;
            port_enabled_reg <= 1'b0;
            for (int i = 0; i < kmns_pkg::ROW_COUNT; i++)
                key_rows_reg[i] <= '0;
        end
        else
        begin
            if (dp_cmd.bus_write)
            begin
                port_enabled_reg <= dp_cmd.write_value[2];
                if (dp_cmd.write_value[2])
                begin
                    row_counter_reg <= row_counter_next;
                    column_half_reg <= dp_cmd.write_value[1];
                end
            end
            if (dp_cmd.key_update && key_row_ok)
            begin
                for (int i = 0; i < kmns_pkg::ROW_COUNT; i++)
                begin
                    if (dp_cmd.key_row == 4'(i))
                    begin
                        if (dp_cmd.key_down)
                            key_rows_reg[i] <= key_rows_reg[i] | dp_cmd.key_bits;
                        else
                            key_rows_reg[i] <= key_rows_reg[i] & ~dp_cmd.key_bits;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.bus_read)
            read_data_reg <= read_data_next;
    end

    assign read_data = read_data_reg;

endmodule

[design/keyboard_matrix_nibble_scanner.sv]
// Top level of the keyboard matrix scanner: controller, datapath and checks.
`timescale 1ns / 1ps

// The block models a keyboard matrix port: it keeps one 8-bit key mask per
// matrix row plus a row counter, a column-half flag and an enable flag. Each
// input item is a bus write, a bus read or a key update; only a bus read
// produces a result item, which carries the inverted, shifted nibble of the
// row under the row counter, or zero while the port is disabled. State
// updates land at the accepting clock edge, and a read result is captured
// in the output register at that same edge, so the block sustains one item
// per cycle unless stalled. The input side stalls only while a result sits
// in the output register and the sink does not take it in that cycle. There
// is no clearing pass after reset; the row masks clear with the reset itself.

module keyboard_matrix_nibble_scanner (
    input  logic       clk,
    input  logic       rst_n,
    kmns_in_if.sink    in_ch,
    kmns_out_if.source out_ch
);

    kmns_pkg::dp_cmd_t dp_cmd;

    // The controller owns the handshakes and turns an accepted item into
    // one-cycle command strobes for the datapath.
    kmns_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .in_cmd      (in_ch.cmd),
        .write_value (in_ch.write_value),
        .key_row     (in_ch.key_row),
        .key_bits    (in_ch.key_bits),
        .key_down    (in_ch.key_down),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .dp_cmd      (dp_cmd)
    );

    // The datapath holds all matrix state and the read result register.
    kmns_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .read_data (out_ch.read_data)
    );

    // An accepted read always shows a result in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.cmd == kmns_pkg::CMD_BUS_READ)
        |=> out_ch.valid)
    else $error("accepted read did not produce a result");

    // Writes and key updates never create a result on their own.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_ch.valid && !(in_ch.valid && in_ch.ready
                            && in_ch.cmd == kmns_pkg::CMD_BUS_READ))
        |=> !out_ch.valid)
    else $error("result appeared without an accepted read");

    // The input side stalls only behind a held result that is not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without a blocked result");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the keyboard matrix nibble scanner.
`timescale 1ns / 1ps

// The testbench drives bus writes, bus reads and key updates into the
// scanner over the valid/ready input channel. It predicts every read result
// with its own model of the row masks, the row counter, the column-half flag
// and the enable flag. Each accepted read result is compared with the oldest
// pending prediction.
//
// The stimulus starts with a short directed part:
//   - a read while the port is disabled,
//   - key presses on the first and last rows, and on rows past the end,
//   - a disabling write with every other bit set,
//   - reads of both column halves,
//   - row advance, the row reset, and a key release,
//   - a write that leaves the port disabled while column select is set.
// A long random part follows. Most of it is scan sequences that a host would
// issue: enable and home the row, then alternate column select high and low
// with a read after each write. That walks the row counter around its wrap
// while key updates change the masks underneath. The rest is key bursts and
// random noise.
//
// Both channels idle in random bursts, and the idling is switched off for
// the last part of the run.
module testbench;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int QUIET_ITEMS   = 250;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 400000;

    // The scoreboard keeps its own copy of the scanner state and a queue of
    // predicted read bytes. Accepted input items update the copy. Bus reads
    // append their predicted byte, and accepted results are checked against
    // the front of the queue.
    class scan_scoreboard;
        logic [7:0] row_masks [kmns_pkg::ROW_COUNT];
        logic [3:0] row_ctr;
        logic       col_half;
        logic       enabled;
        logic [7:0] expected_reads [$];
        int         mismatch_count;

        function new();
            foreach (row_masks[i])
                row_masks[i] = 8'h00;
            row_ctr        = 4'd0;
            col_half       = 1'b0;
            enabled        = 1'b0;
            mismatch_count = 0;
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatch_count++;
        endtask

        // This computes the byte that a bus read returns in the current state.
        function logic [7:0] predict_read();
            logic [7:0] mask;
            logic [3:0] nibble;
            if (!enabled)
                return 8'h00;
            mask   = (row_ctr < kmns_pkg::ROW_COUNT) ? row_masks[row_ctr] : 8'h00;
            nibble = col_half ? mask[3:0] : mask[7:4];
            return ~{3'b000, nibble, 1'b0};
        endfunction

        function void note_item(input logic [1:0] cmd, input logic [7:0] wv,
                                input logic [3:0] row, input logic [7:0] bits,
                                input logic down);
            case (cmd)
                kmns_pkg::CMD_BUS_WRITE:
                begin
                    enabled = wv[2];
                    if (wv[2])
                    begin
                        if (wv[0])
                            row_ctr = 4'd0;
                        else if (!wv[1] && col_half)
                            row_ctr = (int'(row_ctr) + 1 >= kmns_pkg::ROW_COUNT)
                                      ? 4'd0 : row_ctr + 4'd1;
                        col_half = wv[1];
                    end
                end
                kmns_pkg::CMD_BUS_READ:
                    expected_reads = {expected_reads, predict_read()};
                kmns_pkg::CMD_KEY_UPDATE:
                begin
                    if (int'(row) < kmns_pkg::ROW_COUNT)
                        row_masks[row] = down ? (row_masks[row] | bits)
                                              : (row_masks[row] & ~bits);
                end
                default:
                    ;
            endcase
        endfunction

        task check_read(input logic [7:0] data);
            logic [7:0] want;
            if (expected_reads.size() == 0)
            begin
                report_mismatch($sformatf("read result 0x%02h with no read pending", data));
                return;
            end
            want = expected_reads.pop_front();
            if (data !== want)
                report_mismatch($sformatf("read_data 0x%02h, expected 0x%02h", data, want));
        endtask
    endclass

    logic clk;
    logic rst_n;

    kmns_in_if  in_ch();
    kmns_out_if out_ch();

    keyboard_matrix_nibble_scanner DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    scan_scoreboard sb;
    int             cycle_count;
    int             items_sent;
    bit             src_idle_on;
    bit             sink_stall_on;

    initial
    begin
        clk = 1'b0;
        forever
            #(CLK_PERIOD / 2) clk = ~clk;
    end

    // A run that hangs anywhere ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The monitor samples both channels at the clock edge. All testbench
    // drives are nonblocking, so the values seen here are the ones that the
    // block saw at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_item(in_ch.cmd, in_ch.write_value, in_ch.key_row,
                             in_ch.key_bits, in_ch.key_down);
            if (out_ch.valid && out_ch.ready)
                sb.check_read(out_ch.read_data);
        end
    end

    // The result sink is ready most of the time. While stalls are enabled,
    // it now and then drops ready.
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (sink_stall_on && $urandom_range(0, 9) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // This presents one item and returns at the edge that accepts it. Valid
    // stays high into the next item unless an idle burst is inserted first.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] wv,
                             input logic [3:0] row, input logic [7:0] bits,
                             input logic down);
        int gap;
        if (src_idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.write_value <= wv;
        in_ch.key_row     <= row;
        in_ch.key_bits    <= bits;
        in_ch.key_down    <= down;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // The fields that an operation ignores are filled with random values so
    // that they toggle too.
    task automatic send_write(input bit en, input bit col, input bit home);
        send_item(kmns_pkg::CMD_BUS_WRITE, {5'($urandom_range(0, 31)), en, col, home},
                  4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic send_read();
        send_item(kmns_pkg::CMD_BUS_READ, 8'($urandom_range(0, 255)),
                  4'($urandom_range(0, 15)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_key(input logic [3:0] row, input logic [7:0] bits,
                            input logic down);
        send_item(kmns_pkg::CMD_KEY_UPDATE, 8'($urandom_range(0, 255)), row, bits, down);
    endtask

    // Most key updates hit real rows. About one in eight goes past the last
    // row and must be ignored.
    function automatic logic [3:0] pick_row();
        if ($urandom_range(0, 7) == 0)
            return 4'($urandom_range(kmns_pkg::ROW_COUNT, 15));
        return 4'($urandom_range(0, kmns_pkg::ROW_COUNT - 1));
    endfunction

    // This walks the matrix the way a host scan loop does. It homes the row,
    // then for each step selects the low half, reads, selects the high half
    // (which advances the row), and reads again.
    task automatic scan_sequence();
        int steps;
        steps = $urandom_range(1, 2 * kmns_pkg::ROW_COUNT);
        send_write(1'b1, 1'b0, 1'b1);
        repeat (steps)
        begin
            if ($urandom_range(0, 3) == 0)
                send_key(pick_row(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 2) != 0));
            send_write(1'b1, 1'b1, 1'b0);
            send_read();
            send_write(1'b1, 1'b0, 1'b0);
            send_read();
            // An occasional disable in the middle of a scan must freeze the
            // row counter and the column half.
            if ($urandom_range(0, 15) == 0)
            begin
                send_write(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                send_read();
            end
        end
    endtask

    task automatic noise_item();
        send_item(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                  4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int kind;
        int drain;

        sb            = new();
        cycle_count   = 0;
        items_sent    = 0;
        src_idle_on   = 1'b1;
        sink_stall_on = 1'b1;

        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.cmd         <= kmns_pkg::CMD_BUS_WRITE;
        in_ch.write_value <= 8'h00;
        in_ch.key_row     <= 4'd0;
        in_ch.key_bits    <= 8'h00;
        in_ch.key_down    <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A read of the disabled port returns zero.
        send_read();
        // Key presses go on the first and last rows. The presses on rows past
        // the end must leave every mask unchanged.
        send_key(4'd0, 8'hFF, 1'b1);
        send_key(4'(kmns_pkg::ROW_COUNT - 1), 8'hA5, 1'b1);
        send_key(4'(kmns_pkg::ROW_COUNT), 8'hFF, 1'b1);
        send_key(4'd15, 8'hFF, 1'b1);
        // A write with enable clear disables the port and nothing else, even
        // with every other bit set.
        send_item(kmns_pkg::CMD_BUS_WRITE, 8'hFB, 4'd0, 8'h00, 1'b0);
        send_read();
        // This enables the port, homes the row, and reads the high half of row 0.
        send_write(1'b1, 1'b0, 1'b1);
        send_read();
        // Column select low while the half is already low must not advance.
        send_write(1'b1, 1'b0, 1'b0);
        send_read();
        // This reads the low half of row 0.
        send_write(1'b1, 1'b1, 1'b0);
        send_read();
        // Dropping column select advances to row 1, which is empty.
        send_write(1'b1, 1'b0, 1'b0);
        send_read();
        // Row reset wins over the advance, and the column half still follows bit 1.
        send_write(1'b1, 1'b1, 1'b1);
        send_read();
        // A key release clears the low nibble of row 0.
        send_key(4'd0, 8'h0F, 1'b0);
        send_read();
        // A disabling write keeps the column half even with bit 1 set.
        // Re-enabling with bit 1 low then advances the row.
        send_write(1'b0, 1'b1, 1'b0);
        send_read();
        send_write(1'b1, 1'b0, 1'b0);
        send_read();

        // Random part. The idle settings change now and then, and both are
        // off for the last stretch.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= RANDOM_ITEMS - QUIET_ITEMS)
            begin
                src_idle_on   = 1'b0;
                sink_stall_on = 1'b0;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                src_idle_on   = ($urandom_range(0, 3) != 0);
                sink_stall_on = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 9);
            if (kind < 6)
                scan_sequence();
            else if (kind < 8)
                repeat ($urandom_range(1, 8))
                    send_key(pick_row(), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 2) != 0));
            else
                repeat ($urandom_range(1, 10))
                    noise_item();
        end
        in_ch.valid <= 1'b0;

        // Every pending read result must arrive, and then a drain period passes
        // so that any stray result would show up.
        while (sb.expected_reads.size() != 0)
            @(posedge clk);
        drain = DRAIN_CYCLES;
        repeat (drain) @(posedge clk);

        if (sb.mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
